// File: design/capture_linear_resampler_macros.svh
// Assertion helpers shared by the resampler modules.
// Each macro checks a property on the rising edge of the given clock,
// and is switched off while the active-low synchronous reset is held.
`ifndef CAPTURE_LINEAR_RESAMPLER_MACROS_SVH
`define CAPTURE_LINEAR_RESAMPLER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication: when ante holds, cons must hold too.
`define CLR_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define CLR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define CLR_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define CLR_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

// File: design/clr_pkg.sv
`default_nettype none

package clr_pkg;

    // Default values for the top-level parameters.
    localparam int MAX_UPSAMPLE_RATIO_DEF  = 32;
    localparam int PHASE_FRACTION_BITS_DEF = 32;

    // Fixed widths of the phase, the samples and the configuration port.
    localparam int PHASE_W    = 38;
    localparam int SAMPLE_W   = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 38;
    localparam int INTERP_W   = 16;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_IS_S16  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_IS_MONO = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STREAM_IS_S16  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STREAM_IS_MONO = 3'd4;

    // Device frame as it arrives.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] in_left;
        logic signed [SAMPLE_W-1:0] in_right;
    } t_in_frame;

    // Resampled stream frame.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_left;
        logic signed [SAMPLE_W-1:0] out_right;
        logic                       last_of_run;
    } t_out_frame;

    // Device frame after widening to 32-bit stereo.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
    } t_wide_frame;

    // Configuration registers as seen by the front and the back.
    typedef struct packed {
        logic [PHASE_W-1:0] phase_step;
        logic               device_is_s16;
        logic               device_is_mono;
        logic               stream_is_s16;
        logic               stream_is_mono;
    } t_cfg;

    // Sequencer states of the back.
    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_EMIT
    } t_back_state;

endpackage

`default_nettype wire

// File: design/clr_queue.sv
`default_nettype none

module clr_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire clr_pkg::t_wide_frame i_push_data,
    output logic                      o_full,
    input  wire logic                 i_pop,
    output logic                      o_not_empty,
    output clr_pkg::t_wide_frame      o_pop_data
);

`include "capture_linear_resampler_macros.svh"

    clr_pkg::t_wide_frame              r_mem [clr_pkg::QUEUE_DEPTH];
    logic [clr_pkg::QPTR_W-1:0]        r_wr_ptr;
    logic [clr_pkg::QPTR_W-1:0]        r_rd_ptr;
    logic [clr_pkg::QCNT_W-1:0]        r_count;
    logic [clr_pkg::QPTR_W-1:0]        n_wr_ptr;
    logic [clr_pkg::QPTR_W-1:0]        n_rd_ptr;
    logic [clr_pkg::QCNT_W-1:0]        n_count;

    assign o_full      = (r_count == clr_pkg::QCNT_W'(clr_pkg::QUEUE_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_pop_data  = r_mem[r_rd_ptr];

    // Pointer and fill level updates, wrapping at the queue depth.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == clr_pkg::QPTR_W'(clr_pkg::QUEUE_DEPTH - 1))
                       ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == clr_pkg::QPTR_W'(clr_pkg::QUEUE_DEPTH - 1))
                       ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    `CLR_ASSERT_IMPL(a_no_pop_when_empty, i_clk, i_rst_n, i_pop, r_count != '0)
    `CLR_ASSERT_IMPL(a_fill_in_range, i_clk, i_rst_n, 1'b1, r_count <= clr_pkg::QCNT_W'(clr_pkg::QUEUE_DEPTH))

endmodule

`default_nettype wire

// File: design/clr_front.sv
`default_nettype none

module clr_front (
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire clr_pkg::t_in_frame   i_in_data,
    input  wire clr_pkg::t_cfg        i_cfg,
    input  wire logic                 i_queue_full,
    output logic                      o_push,
    output clr_pkg::t_wide_frame      o_push_data
);

    logic signed [clr_pkg::SAMPLE_W-1:0] wide_left;
    logic signed [clr_pkg::SAMPLE_W-1:0] wide_right;

    // A transaction is taken whenever the queue has room.
    assign o_in_stall = i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full;

    // Widen 16-bit device samples into the top half; a mono device copies left.
    always_comb begin
        if (i_cfg.device_is_s16) begin
            wide_left  = {i_in_data.in_left[15:0], 16'h0000};
            wide_right = {i_in_data.in_right[15:0], 16'h0000};
        end else begin
            wide_left  = i_in_data.in_left;
            wide_right = i_in_data.in_right;
        end
        o_push_data.left  = wide_left;
        o_push_data.right = i_cfg.device_is_mono ? wide_left : wide_right;
    end

endmodule

`default_nettype wire

// File: design/clr_back.sv
`default_nettype none

module clr_back #(
    parameter int MAX_UPSAMPLE_RATIO  = clr_pkg::MAX_UPSAMPLE_RATIO_DEF,
    parameter int PHASE_FRACTION_BITS = clr_pkg::PHASE_FRACTION_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire clr_pkg::t_cfg        i_cfg,
    input  wire logic                 i_not_empty,
    input  wire clr_pkg::t_wide_frame i_frame,
    output logic                      o_pop,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output clr_pkg::t_out_frame       o_out_data
);

`include "capture_linear_resampler_macros.svh"

    localparam int CNT_W  = $clog2(MAX_UPSAMPLE_RATIO + 1);
    localparam int SW     = clr_pkg::SAMPLE_W;
    localparam int PW     = clr_pkg::PHASE_W;
    localparam int DIFF_W = SW + 1;
    localparam int PROD_W = DIFF_W + clr_pkg::INTERP_W + 1;
    localparam logic [PW-1:0] WHOLE_FRAME = PW'(1) << PHASE_FRACTION_BITS;
    localparam logic [PW-1:0] PHASE_MAX   = '1;

    clr_pkg::t_back_state        r_state, n_state;
    logic [PW-1:0]               r_phase, n_phase;
    logic [CNT_W-1:0]            r_cnt, n_cnt;
    logic                        r_last, n_last;
    logic                        r_use_new, n_use_new;
    logic signed [SW-1:0]        r_prev_l, n_prev_l;
    logic signed [SW-1:0]        r_prev_r, n_prev_r;
    logic signed [SW-1:0]        r_new_l, n_new_l;
    logic signed [SW-1:0]        r_new_r, n_new_r;
    logic signed [PROD_W-1:0]    r_prod_l, n_prod_l;
    logic signed [PROD_W-1:0]    r_prod_r, n_prod_r;
    logic                        r_out_valid, n_out_valid;
    clr_pkg::t_out_frame         r_out, n_out;

    logic [PW:0]                        phase_sum;
    logic [PW-1:0]                      phase_next;
    logic [PW-1:0]                      phase_wrapped;
    logic [clr_pkg::INTERP_W-1:0]       frac_top;
    logic signed [DIFF_W-1:0]           diff_l;
    logic signed [DIFF_W-1:0]           diff_r;
    logic signed [PROD_W-1:0]           mul_l;
    logic signed [PROD_W-1:0]           mul_r;
    logic signed [SW+1:0]               interp_l;
    logic signed [SW+1:0]               interp_r;
    logic signed [SW-1:0]               samp_l;
    logic signed [SW-1:0]               samp_r;
    logic signed [SW:0]                 pair_sum;
    logic signed [SW:0]                 pair_avg;
    logic signed [SW-1:0]               mixed_l;
    logic signed [SW-1:0]               mixed_r;
    logic                               slot_free;
    logic                               in_run;

    // Phase stepping: saturating add, then whole-frame removal at the end of a run.
    assign phase_sum     = {1'b0, r_phase} + {1'b0, i_cfg.phase_step};
    assign phase_next    = phase_sum[PW] ? PHASE_MAX : phase_sum[PW-1:0];
    assign phase_wrapped = (r_phase >= WHOLE_FRAME) ? (r_phase - WHOLE_FRAME) : '0;
    assign in_run        = (r_phase <= WHOLE_FRAME);

    // Interpolation products between the previous and the new frame.
    assign frac_top = r_phase[PHASE_FRACTION_BITS-1 -: clr_pkg::INTERP_W];
    assign diff_l   = DIFF_W'(r_new_l) - DIFF_W'(r_prev_l);
    assign diff_r   = DIFF_W'(r_new_r) - DIFF_W'(r_prev_r);
    assign mul_l    = diff_l * $signed({1'b0, frac_top});
    assign mul_r    = diff_r * $signed({1'b0, frac_top});

    // Sample selection and floor-shifted interpolation; results stay in 32 bits.
    assign interp_l = r_use_new ? (SW+2)'(r_new_l)
                    : (SW+2)'(r_prev_l) + r_prod_l[PROD_W-1 -: SW+2];
    assign interp_r = r_use_new ? (SW+2)'(r_new_r)
                    : (SW+2)'(r_prev_r) + r_prod_r[PROD_W-1 -: SW+2];
    assign samp_l   = interp_l[SW-1:0];
    assign samp_r   = interp_r[SW-1:0];

    // Mono average truncated toward zero.
    assign pair_sum = (SW+1)'(samp_l) + (SW+1)'(samp_r);
    assign pair_avg = (pair_sum + (SW+1)'(pair_sum[SW])) >>> 1;
    assign mixed_l  = i_cfg.stream_is_mono ? pair_avg[SW-1:0] : samp_l;
    assign mixed_r  = i_cfg.stream_is_mono ? pair_avg[SW-1:0] : samp_r;

    assign slot_free   = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Sequencer: take a frame, then alternate multiply and emit per output until the run ends.
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_last      = r_last;
        n_use_new   = r_use_new;
        n_prev_l    = r_prev_l;
        n_prev_r    = r_prev_r;
        n_new_l     = r_new_l;
        n_new_r     = r_new_r;
        n_prod_l    = r_prod_l;
        n_prod_r    = r_prod_r;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        o_pop       = 1'b0;
        unique case (r_state)
            clr_pkg::S_IDLE: begin
                if (i_not_empty) begin
                    o_pop   = 1'b1;
                    n_new_l = i_frame.left;
                    n_new_r = i_frame.right;
                    n_cnt   = '0;
                    n_state = clr_pkg::S_MUL;
                end
            end
            clr_pkg::S_MUL: begin
                if (in_run) begin
                    n_prod_l  = mul_l;
                    n_prod_r  = mul_r;
                    n_use_new = (r_phase == WHOLE_FRAME);
                    n_last    = (r_cnt == CNT_W'(MAX_UPSAMPLE_RATIO - 1))
                                || (phase_next > WHOLE_FRAME);
                    n_cnt     = r_cnt + 1'b1;
                    n_phase   = phase_next;
                    n_state   = clr_pkg::S_EMIT;
                end else begin
                    // Run ends with no output for this frame.
                    n_phase  = phase_wrapped;
                    n_prev_l = r_new_l;
                    n_prev_r = r_new_r;
                    n_state  = clr_pkg::S_IDLE;
                end
            end
            clr_pkg::S_EMIT: begin
                if (slot_free) begin
                    n_out_valid       = 1'b1;
                    n_out.out_left    = i_cfg.stream_is_s16 ? (mixed_l >>> 16) : mixed_l;
                    n_out.out_right   = i_cfg.stream_is_s16 ? (mixed_r >>> 16) : mixed_r;
                    n_out.last_of_run = r_last;
                    if (r_last) begin
                        n_phase  = phase_wrapped;
                        n_prev_l = r_new_l;
                        n_prev_r = r_new_r;
                        n_state  = clr_pkg::S_IDLE;
                    end else begin
                        n_state  = clr_pkg::S_MUL;
                    end
                end
            end
            default: begin
                n_state = clr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= clr_pkg::S_IDLE;
            r_phase     <= WHOLE_FRAME;
            r_prev_l    <= '0;
            r_prev_r    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_prev_l    <= n_prev_l;
            r_prev_r    <= n_prev_r;
            r_out_valid <= n_out_valid;
        end
    end

    // Working registers of the current frame.
    always_ff @(posedge i_clk) begin
        r_cnt     <= n_cnt;
        r_last    <= n_last;
        r_use_new <= n_use_new;
        r_new_l   <= n_new_l;
        r_new_r   <= n_new_r;
        r_prod_l  <= n_prod_l;
        r_prod_r  <= n_prod_r;
        r_out     <= n_out;
    end

    `CLR_ASSERT_IMPL(a_emit_count_in_range, i_clk, i_rst_n, r_state == clr_pkg::S_EMIT, (r_cnt != '0) && (r_cnt <= CNT_W'(MAX_UPSAMPLE_RATIO)))
    `CLR_ASSERT_IMPL(a_idle_phase_reduced, i_clk, i_rst_n, r_state == clr_pkg::S_IDLE, r_phase <= (PHASE_MAX - WHOLE_FRAME))
    `CLR_ASSERT_IMPL(a_output_from_emit, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == clr_pkg::S_EMIT)

endmodule

`default_nettype wire

// File: design/capture_linear_resampler.sv
// Capture-side linear-interpolation sample-rate converter.
// Input channel: one device stereo frame per transaction (i_in_valid, o_in_stall,
// i_in_data). Output channel: resampled stream frames (o_out_valid, i_out_stall,
// o_out_data); last_of_run marks the final frame caused by one input frame, and
// an input frame may cause none.
// Configuration: write i_cfg_data to register i_cfg_index while i_cfg_we is high;
// write only while the block is idle. Indexes past the last register are ignored.
// A front stage widens each device frame and places it in a two-entry queue; a
// back sequencer takes one frame at a time from the queue in its idle state, then
// passes through a multiply state and an emit state for each output, at most 32
// outputs at the default cap; a frame that causes none leaves the multiply state
// for idle without emitting. An input frame's first output passes through the
// queue, the idle take, the multiply state and the output register that the emit
// state loads.
// Reset (synchronous, active low) empties the queue, restores the configuration,
// idles the back, sets the phase to a whole frame and zeroes the previous frame.
// A stall on the output holds the registered result; the back waits in its emit
// cycle, and the queue keeps taking input frames until it is full.
`default_nettype none

module capture_linear_resampler #(
    parameter int MAX_UPSAMPLE_RATIO  = clr_pkg::MAX_UPSAMPLE_RATIO_DEF,
    parameter int PHASE_FRACTION_BITS = clr_pkg::PHASE_FRACTION_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire clr_pkg::t_in_frame                  i_in_data,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output clr_pkg::t_out_frame                      o_out_data,
    input  wire logic                                i_cfg_we,
    input  wire logic [clr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [clr_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    clr_pkg::t_cfg           r_cfg;
    clr_pkg::t_cfg           n_cfg;
    clr_pkg::t_wide_frame    push_data;
    clr_pkg::t_wide_frame    pop_data;
    logic                    push;
    logic                    pop;
    logic                    queue_full;
    logic                    queue_not_empty;

    // Configuration register writes.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                clr_pkg::CFG_PHASE_STEP:     n_cfg.phase_step     = i_cfg_data[clr_pkg::PHASE_W-1:0];
                clr_pkg::CFG_DEVICE_IS_S16:  n_cfg.device_is_s16  = i_cfg_data[0];
                clr_pkg::CFG_DEVICE_IS_MONO: n_cfg.device_is_mono = i_cfg_data[0];
                clr_pkg::CFG_STREAM_IS_S16:  n_cfg.stream_is_s16  = i_cfg_data[0];
                clr_pkg::CFG_STREAM_IS_MONO: n_cfg.stream_is_mono = i_cfg_data[0];
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_step     <= clr_pkg::PHASE_W'(1) << PHASE_FRACTION_BITS;
            r_cfg.device_is_s16  <= 1'b0;
            r_cfg.device_is_mono <= 1'b0;
            r_cfg.stream_is_s16  <= 1'b0;
            r_cfg.stream_is_mono <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    clr_front u_front (
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_cfg        (r_cfg),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_push_data  (push_data)
    );

    clr_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (queue_full),
        .i_pop       (pop),
        .o_not_empty (queue_not_empty),
        .o_pop_data  (pop_data)
    );

    clr_back #(
        .MAX_UPSAMPLE_RATIO  (MAX_UPSAMPLE_RATIO),
        .PHASE_FRACTION_BITS (PHASE_FRACTION_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_not_empty (queue_not_empty),
        .i_frame     (pop_data),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
